/* rtl/bcfg_pkg.sv */
// Package for the emulated type-1 bridge configuration header.
// Holds the beat payload types, the dword map codes and the access size codes.
// Used by bcfg_win, bcfg_core and pci_bridge_config_space.
package bcfg_pkg;

    // Input beat: one configuration access.
    typedef struct packed {
        logic        command;
        logic [11:0] offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } bcfg_in_t;

    // Result beat: read data, status and the decode window state after the access.
    typedef struct packed {
        logic [31:0] read_data;
        logic        status;
        logic [32:0] io_window_base;
        logic [32:0] io_window_size;
        logic [31:0] mem_window_base;
        logic [32:0] mem_window_size;
        logic [7:0]  local_bus_number;
        logic        local_bus_update;
    } bcfg_out_t;

    // Software-written configuration registers.
    typedef struct packed {
        logic [15:0] device_id;
        logic [7:0]  revision_id;
        logic        io_port_present;
        logic [31:0] io_window_offset;
    } bcfg_cfg_t;

    // Decode window state.
    typedef struct packed {
        logic [32:0] io_base;
        logic [32:0] io_size;
        logic [31:0] mem_base;
        logic [32:0] mem_size;
    } bcfg_win_t;

    // Bridge header registers that feed the window computation.
    typedef struct packed {
        logic [15:0] command;
        logic [7:0]  io_base_low;
        logic [7:0]  io_limit_low;
        logic [15:0] io_base_high;
        logic [15:0] io_limit_high;
        logic [15:0] mem_base;
        logic [15:0] mem_limit;
    } bcfg_hdr_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_DEVICE_ID        = 8'd0;
    localparam logic [7:0] CFG_REVISION_ID      = 8'd1;
    localparam logic [7:0] CFG_IO_PORT_PRESENT  = 8'd2;
    localparam logic [7:0] CFG_IO_WINDOW_OFFSET = 8'd3;

    // Access commands.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Access sizes in bytes.
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_WORD  = 3'd2;
    localparam logic [2:0] SIZE_DWORD = 3'd4;

    // Dword addresses (byte offset bits 11:2).
    localparam logic [9:0] DW_ID       = 10'h000;
    localparam logic [9:0] DW_CMD      = 10'h001;
    localparam logic [9:0] DW_CLASS    = 10'h002;
    localparam logic [9:0] DW_HDR      = 10'h003;
    localparam logic [9:0] DW_BAR0     = 10'h004;
    localparam logic [9:0] DW_BAR1     = 10'h005;
    localparam logic [9:0] DW_BUS      = 10'h006;
    localparam logic [9:0] DW_IO_LOW   = 10'h007;
    localparam logic [9:0] DW_MEM      = 10'h008;
    localparam logic [9:0] DW_PREF     = 10'h009;
    localparam logic [9:0] DW_IO_HIGH  = 10'h00C;
    localparam logic [9:0] DW_ROM      = 10'h00E;
    localparam logic [9:0] DW_INTR     = 10'h00F;

    // Fixed header contents.
    localparam logic [15:0] VENDOR_ID   = 16'h11ab;
    localparam logic [15:0] CLASS_CODE  = 16'h0604;
    localparam logic [31:0] HDR_DWORD   = 32'h0001_0010;
    localparam logic [7:0]  IO_LOW_RST  = 8'h01;

endpackage

/* rtl/pci_bridge_config_space.sv */
// Emulated type-1 bridge configuration header, top level.
// Input and result registers around bcfg_core; configuration registers.
// Depends on bcfg_pkg and bcfg_core.
//
// Usage:
// - s_valid/s_ready/s_data carry one configuration access per beat: read or
//   write, byte offset, access size and right-aligned write data.
// - m_valid/m_ready/m_data return one result beat per access: read data,
//   status, the I/O and memory decode windows after the access, and the
//   secondary bus number when the bus-number dword was written.
// - cfg_valid/cfg_ready/cfg_index/cfg_data write the device id, revision,
//   I/O target presence and I/O window offset; cfg_ready is always high.
// - An accepted input beat passes through the input register and then the
//   result register to its result beat. Decode, lane merge and window
//   arithmetic sit between the two registers.
// - Throughput is one access per cycle while the receiver takes results; the header
//   state is updated as an access moves into the result register, so the next access sees it.
// - When the receiver stalls, the result register holds its beat and the
//   input register fills; s_ready drops once both are occupied.
// - Reset clears both pipeline registers and restores the header registers
//   and configuration registers to their reset values.
module pci_bridge_config_space (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bcfg_pkg::bcfg_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bcfg_pkg::bcfg_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    bcfg_pkg::bcfg_cfg_t cfg_reg, cfg_next;
    bcfg_pkg::bcfg_in_t  in_reg;
    bcfg_pkg::bcfg_out_t out_reg;
    bcfg_pkg::bcfg_out_t result;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                advance;

    // Pipeline flow control: an access advances when the result register is empty or its beat is taken.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // Configuration register decoder.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bcfg_pkg::CFG_DEVICE_ID:        cfg_next.device_id        = cfg_data[15:0];
                bcfg_pkg::CFG_REVISION_ID:      cfg_next.revision_id      = cfg_data[7:0];
                bcfg_pkg::CFG_IO_PORT_PRESENT:  cfg_next.io_port_present  = cfg_data[0];
                bcfg_pkg::CFG_IO_WINDOW_OFFSET: cfg_next.io_window_offset = cfg_data;
                default: ;
            endcase
        end
    end

    bcfg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/bcfg_win.sv */
// Decode window computation for the bridge header.
// Recomputes, clears or holds the I/O and memory windows from the updated header registers.
// Depends on bcfg_pkg.
module bcfg_win (
    input  bcfg_pkg::bcfg_hdr_t hdr,
    input  logic                io_port_present,
    input  logic [31:0]         io_window_offset,
    input  logic                io_upd,
    input  logic                mem_upd,
    input  bcfg_pkg::bcfg_win_t win_cur,
    output bcfg_pkg::bcfg_win_t win_new
);

    logic        io_invalid;
    logic        mem_invalid;
    logic [31:0] io_bus_base;
    logic [31:0] io_top;
    logic [31:0] mem_base;
    logic [31:0] mem_top;

    // Bus-side window edges; the type nibble of the low bytes is masked off.
    assign io_bus_base = {hdr.io_base_high, hdr.io_base_low[7:4], 12'h000};
    assign io_top      = {hdr.io_limit_high, hdr.io_limit_low[7:4], 12'hFFF};
    assign mem_base    = {hdr.mem_base[15:4], 20'h00000};
    assign mem_top     = {hdr.mem_limit[15:4], 20'hFFFFF};

    assign io_invalid  = (hdr.io_limit_low < hdr.io_base_low)
                       || (hdr.io_limit_high < hdr.io_base_high)
                       || !hdr.command[0];
    assign mem_invalid = (hdr.mem_limit < hdr.mem_base) || !hdr.command[1];

    // I/O window: clear when invalid, hold when no I/O target exists; memory window: clear when invalid.
    always_comb begin
        win_new = win_cur;
        if (io_upd) begin
            if (io_invalid) begin
                win_new.io_base = '0;
                win_new.io_size = '0;
            end else if (io_port_present) begin
                win_new.io_base = {1'b0, io_window_offset} + {1'b0, io_bus_base};
                win_new.io_size = {1'b0, io_top} - {1'b0, io_bus_base} + 33'd1;
            end
        end
        if (mem_upd) begin
            if (mem_invalid) begin
                win_new.mem_base = '0;
                win_new.mem_size = '0;
            end else begin
                win_new.mem_base = mem_base;
                win_new.mem_size = {1'b0, mem_top} - {1'b0, mem_base} + 33'd1;
            end
        end
    end

endmodule

/* rtl/bcfg_core.sv */
// Register file and access logic of the bridge header.
// Decodes one access, merges write lanes, updates state and forms the result.
// Depends on bcfg_pkg and bcfg_win.
module bcfg_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  bcfg_pkg::bcfg_in_t  item,
    input  bcfg_pkg::bcfg_cfg_t cfg,
    output bcfg_pkg::bcfg_out_t result
);

    bcfg_pkg::bcfg_hdr_t hdr_reg, hdr_next;
    bcfg_pkg::bcfg_win_t win_reg, win_next;
    logic [31:0] bar0_reg, bar0_next;
    logic [31:0] bar1_reg, bar1_next;
    logic [31:0] bus_reg, bus_next;

    logic [9:0]  dw;
    logic [4:0]  shift;
    logic        known;
    logic [31:0] cur;
    logic [31:0] cur_shifted;
    logic        size_ok;
    logic [31:0] lane_mask;
    logic [31:0] keep;
    logic [31:0] merged;
    logic        is_write;
    logic        wr_ok;
    logic        io_upd;
    logic        mem_upd;

    assign dw       = item.offset[11:2];
    assign shift    = {item.offset[1:0], 3'b000};
    assign is_write = (item.command == bcfg_pkg::CMD_WRITE);

    // Read map decoder.
    always_comb begin
        known = 1'b1;
        unique case (dw)
            bcfg_pkg::DW_ID:      cur = {cfg.device_id, bcfg_pkg::VENDOR_ID};
            bcfg_pkg::DW_CMD:     cur = {16'h0000, hdr_reg.command};
            bcfg_pkg::DW_CLASS:   cur = {bcfg_pkg::CLASS_CODE, 8'h00, cfg.revision_id};
            bcfg_pkg::DW_HDR:     cur = bcfg_pkg::HDR_DWORD;
            bcfg_pkg::DW_BAR0:    cur = bar0_reg;
            bcfg_pkg::DW_BAR1:    cur = bar1_reg;
            bcfg_pkg::DW_BUS:     cur = bus_reg;
            bcfg_pkg::DW_IO_LOW:  cur = cfg.io_port_present
                                      ? {16'h0000, hdr_reg.io_limit_low, hdr_reg.io_base_low}
                                      : 32'h0;
            bcfg_pkg::DW_MEM:     cur = {hdr_reg.mem_limit, hdr_reg.mem_base};
            bcfg_pkg::DW_IO_HIGH: cur = {hdr_reg.io_limit_high, hdr_reg.io_base_high};
            bcfg_pkg::DW_PREF,
            bcfg_pkg::DW_ROM,
            bcfg_pkg::DW_INTR:    cur = 32'h0;
            default: begin
                cur   = 32'hFFFF_FFFF;
                known = 1'b0;
            end
        endcase
    end

    // Lane mask from the access size; other sizes are rejected on writes.
    always_comb begin
        size_ok = 1'b1;
        case (item.access_size)
            bcfg_pkg::SIZE_DWORD: lane_mask = 32'hFFFF_FFFF;
            bcfg_pkg::SIZE_WORD:  lane_mask = 32'h0000_FFFF;
            bcfg_pkg::SIZE_BYTE:  lane_mask = 32'h0000_00FF;
            default: begin
                lane_mask = 32'h0;
                size_ok   = 1'b0;
            end
        endcase
    end

    // Byte lane merge of the write data into the current dword.
    assign keep   = (item.access_size == bcfg_pkg::SIZE_DWORD) ? 32'h0 : ~(lane_mask << shift);
    assign merged = (cur & keep) | ((item.write_data & lane_mask) << shift);
    assign wr_ok  = fire && is_write && size_ok && known;

    // Register updates of a successful write.
    always_comb begin
        hdr_next  = hdr_reg;
        bar0_next = bar0_reg;
        bar1_next = bar1_reg;
        bus_next  = bus_reg;
        if (wr_ok) begin
            case (dw)
                bcfg_pkg::DW_CMD: begin
                    hdr_next.command    = merged[15:0];
                    hdr_next.command[0] = merged[0] & cfg.io_port_present;
                end
                bcfg_pkg::DW_BAR0:    bar0_next = merged;
                bcfg_pkg::DW_BAR1:    bar1_next = merged;
                bcfg_pkg::DW_BUS:     bus_next  = merged;
                bcfg_pkg::DW_IO_LOW: begin
                    hdr_next.io_base_low  = merged[7:0] | bcfg_pkg::IO_LOW_RST;
                    hdr_next.io_limit_low = merged[15:8] | bcfg_pkg::IO_LOW_RST;
                end
                bcfg_pkg::DW_MEM: begin
                    hdr_next.mem_base  = merged[15:0];
                    hdr_next.mem_limit = merged[31:16];
                end
                bcfg_pkg::DW_IO_HIGH: begin
                    hdr_next.io_base_high  = merged[15:0];
                    hdr_next.io_limit_high = merged[31:16];
                end
                default: ;
            endcase
        end
    end

    // Window recomputation triggers.
    assign io_upd  = wr_ok && (((dw == bcfg_pkg::DW_CMD)
                              && (hdr_next.command[0] != hdr_reg.command[0]))
                             || (dw == bcfg_pkg::DW_IO_LOW) || (dw == bcfg_pkg::DW_IO_HIGH));
    assign mem_upd = wr_ok && (((dw == bcfg_pkg::DW_CMD)
                              && (hdr_next.command[1] != hdr_reg.command[1]))
                             || (dw == bcfg_pkg::DW_MEM));

    bcfg_win u_win (
        .hdr              (hdr_next),
        .io_port_present  (cfg.io_port_present),
        .io_window_offset (cfg.io_window_offset),
        .io_upd           (io_upd),
        .mem_upd          (mem_upd),
        .win_cur          (win_reg),
        .win_new          (win_next)
    );

    // Header state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= '{command: 16'h0, io_base_low: bcfg_pkg::IO_LOW_RST,
                         io_limit_low: bcfg_pkg::IO_LOW_RST, io_base_high: 16'h0,
                         io_limit_high: 16'h0, mem_base: 16'h0, mem_limit: 16'h0};
            win_reg  <= '0;
            bar0_reg <= '0;
            bar1_reg <= '0;
            bus_reg  <= '0;
        end else begin
            hdr_reg  <= hdr_next;
            win_reg  <= win_next;
            bar0_reg <= bar0_next;
            bar1_reg <= bar1_next;
            bus_reg  <= bus_next;
        end
    end

    // Read data is aligned to the addressed lane and masked to the size.
    assign cur_shifted = cur >> shift;

    always_comb begin
        result = '0;
        if (is_write) begin
            result.status = !(size_ok && known);
        end else if (!known) begin
            result.read_data = 32'hFFFF_FFFF;
            result.status    = 1'b1;
        end else begin
            case (item.access_size)
                bcfg_pkg::SIZE_WORD: result.read_data = cur_shifted & 32'h0000_FFFF;
                bcfg_pkg::SIZE_BYTE: result.read_data = cur_shifted & 32'h0000_00FF;
                default:             result.read_data = cur;
            endcase
        end
        result.io_window_base  = win_next.io_base;
        result.io_window_size  = win_next.io_size;
        result.mem_window_base = win_next.mem_base;
        result.mem_window_size = win_next.mem_size;
        if (wr_ok && (dw == bcfg_pkg::DW_BUS)) begin
            result.local_bus_update = 1'b1;
            result.local_bus_number = merged[15:8];
        end
    end

endmodule
